### src/ipsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsv_pkg: shared types, constants and arithmetic helpers
// Q24 and Q30 constants, the sector code, the result payload and the sine sample
// generator used to build the lookup table at elaboration.
// ----------------------------------------------------------------------------
package ipsv_pkg;

	localparam logic signed [31:0] Q24_ONE        = 32'sd16777216;
	localparam logic signed [31:0] Q24_HALF       = 32'sd8388608;
	localparam logic signed [31:0] SQRT3_HALF_Q24 = 32'sd14529495;
	localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;

	// Sector as the three sign tests {vc > 0, vb > 0, va > 0}
	typedef enum logic [2:0] {
		SECT_NONE = 3'd0,
		SECT_1    = 3'd1,
		SECT_2    = 3'd2,
		SECT_3    = 3'd3,
		SECT_4    = 3'd4,
		SECT_5    = 3'd5,
		SECT_6    = 3'd6,
		SECT_ALL  = 3'd7
	} sector_t;

	// One result transaction
	typedef struct packed {
		logic signed [31:0] bottom_command;
		logic signed [31:0] top_command;
	} result_t;

	// Q24 product: exact 64-bit product, arithmetic shift by 24, keep 32 bits
	function automatic logic signed [31:0] mul_q24(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] prod;
		prod = 64'(a) * 64'(b);
		return prod[55:24];
	endfunction

	// Taylor term divisor (2n)(2n+1)
	function automatic logic [63:0] div_term(input logic [63:0] v, input int n);
		case (n)
			1:       return v / 6;
			2:       return v / 20;
			3:       return v / 42;
			4:       return v / 72;
			5:       return v / 110;
			6:       return v / 156;
			7:       return v / 210;
			8:       return v / 272;
			9:       return v / 342;
			10:      return v / 420;
			default: return v;
		endcase
	endfunction

	// Q24 sine of a 32-bit phase (one turn = 2^32), first-quadrant Taylor in Q30
	function automatic logic signed [31:0] sine_sample(input logic [63:0] phase);
		logic [1:0]         quad;
		logic [63:0]        r;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		logic signed [31:0] v;
		quad = phase[31:30];
		r    = {34'd0, phase[29:0]};
		if (quad[0])
			r = 64'h4000_0000 - r;
		x   = (r * HALF_PI_Q30) >> 30;
		x2  = (x * x) >> 30;
		mag = x;
		sum = signed'(x);
		for (int n = 1; n <= 10; n++) begin
			mag = div_term((mag * x2) >> 30, n);
			if (n % 2 == 1)
				sum = sum - signed'(mag);
			else
				sum = sum + signed'(mag);
		end
		if (sum < 0)
			sum = '0;
		if (sum > 64'sh4000_0000)
			sum = 64'sh4000_0000;
		v = 32'((unsigned'(sum) + 64'd32) >> 6);
		return quad[1] ? -v : v;
	endfunction

endpackage
`default_nettype wire

### src/inverse_park_svpwm_phase_a_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_park_svpwm_phase_a_drive: inverse Park rotation, SVPWM phase A drive
// Rotates a Q24 alpha/beta vector by a per-unit angle, decodes the space
// vector sector and turns phase A's duty into gain-scaled predriver commands.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload (low bits first)
//  s_axis    in         angle_pu[24], alpha_volt[32], beta_volt[32], drive_gain[32]
//  m_axis    out        top_command[32], bottom_command[32]
//
// One transaction accepted per cycle while the skid entry is empty; each gives one result.
// The pipeline has nine register stages (index multiply, sine/cosine table
// read, rotation products, rotation sums, sqrt(3)/2 product, sector decode,
// duty, drive scaling, gain products) ahead of an output register.
// The whole pipeline holds while the skid entry is full; s_axis_tready is
// a flop. arst_n clears all valid bits; the table is constant.
// ----------------------------------------------------------------------------
module inverse_park_svpwm_phase_a_drive #(
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [23:0] angle_pu, [55:24] alpha_volt, [87:56] beta_volt, [119:88] drive_gain
	input  wire logic [119:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] top_command, [63:32] bottom_command
	output logic [63:0]       m_axis_tdata
);
	import ipsv_pkg::*;

	localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES);
	localparam int PROD_W = 24 + $clog2(SINE_TABLE_ENTRIES + 1);

	logic en;

	// Input fields
	logic [23:0]        angle_pu;
	logic signed [31:0] alpha_volt;
	logic signed [31:0] beta_volt;
	logic signed [31:0] drive_gain;
	logic [23:0]        cos_angle;
	logic [PROD_W-1:0]  sin_prod;
	logic [PROD_W-1:0]  cos_prod;

	assign angle_pu   = s_axis_tdata[23:0];
	assign alpha_volt = s_axis_tdata[55:24];
	assign beta_volt  = s_axis_tdata[87:56];
	assign drive_gain = s_axis_tdata[119:88];

	// Table indices: (angle * N) >> 24, cosine a quarter turn ahead
	assign cos_angle = angle_pu + 24'h40_0000;
	assign sin_prod  = PROD_W'(angle_pu) * PROD_W'(SINE_TABLE_ENTRIES);
	assign cos_prod  = PROD_W'(cos_angle) * PROD_W'(SINE_TABLE_ENTRIES);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s7, v_s8, v_s9;
	logic v_s6;

	logic [IDX_W-1:0]   sin_idx_s1, cos_idx_s1;
	logic signed [31:0] alpha_s1, beta_s1, alpha_s2, beta_s2;
	logic signed [31:0] sin_s2, cos_s2;
	logic signed [31:0] ac_s3, bs_s3, bc_s3, as_s3;
	logic signed [31:0] a1_s4, b1_s4;
	logic signed [31:0] ka_s5, kb_s5, va_s5;
	logic signed [31:0] ta_s7;
	logic signed [31:0] dm_s8, dp_s8;
	logic signed [31:0] mt_s9, mb_s9;
	logic signed [31:0] gain_s1, gain_s2, gain_s3, gain_s4, gain_s5;
	logic signed [31:0] gain_s6, gain_s7, gain_s8;
	logic signed [31:0] da;

	result_t res_next;
	result_t res_out;

	assign da = Q24_ONE - (ta_s7 <<< 1);

	// Index stage
	always_ff @(posedge clk) begin
		if (en) begin
			sin_idx_s1 <= sin_prod[24 +: IDX_W];
			cos_idx_s1 <= cos_prod[24 +: IDX_W];
			alpha_s1   <= alpha_volt;
			beta_s1    <= beta_volt;
			gain_s1    <= drive_gain;
		end
	end

	ipsv_sine_rom #(
		.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
	) u_rom (
		.clk    (clk),
		.en     (en),
		.sin_idx(sin_idx_s1),
		.cos_idx(cos_idx_s1),
		.sin_s2 (sin_s2),
		.cos_s2 (cos_s2)
	);

	// Rotation products, sums, sqrt(3)/2 scaling
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s2 <= alpha_s1;
			beta_s2  <= beta_s1;
			gain_s2  <= gain_s1;

			ac_s3   <= mul_q24(alpha_s2, cos_s2);
			bs_s3   <= mul_q24(beta_s2, sin_s2);
			bc_s3   <= mul_q24(beta_s2, cos_s2);
			as_s3   <= mul_q24(alpha_s2, sin_s2);
			gain_s3 <= gain_s2;

			a1_s4   <= ac_s3 + bs_s3;
			b1_s4   <= bc_s3 - as_s3;
			gain_s4 <= gain_s3;

			ka_s5   <= mul_q24(a1_s4, SQRT3_HALF_Q24);
			kb_s5   <= b1_s4 >>> 1;
			va_s5   <= b1_s4;
			gain_s5 <= gain_s4;

			gain_s6 <= gain_s5;
			gain_s7 <= gain_s6;
		end
	end

	ipsv_duty u_duty (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_s5(v_s5),
		.va_s5   (va_s5),
		.ka_s5   (ka_s5),
		.kb_s5   (kb_s5),
		.valid_s7(v_s7),
		.ta_s7   (ta_s7)
	);

	// Drive scaling and gain products
	always_ff @(posedge clk) begin
		if (en) begin
			dm_s8   <= da - Q24_ONE;
			dp_s8   <= da + Q24_ONE;
			gain_s8 <= gain_s7;

			mt_s9 <= mul_q24(gain_s8, dm_s8);
			mb_s9 <= mul_q24(gain_s8, dp_s8);
		end
	end

	// Advance valid bits; the stage 7 valid lives in the duty unit, which keeps its own stage 6 valid too
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Final offsets into the output register
	assign res_next.top_command    = Q24_ONE + (mt_s9 >>> 1);
	assign res_next.bottom_command = -Q24_ONE + (mb_s9 >>> 1);

	ipsv_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_ready (en),
		.in_data  (res_next),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (res_out)
	);

	assign s_axis_tready = en;
	assign m_axis_tdata  = {res_out.bottom_command, res_out.top_command};

	// A full skid entry means a result is waiting at the output
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("pipeline stalled with no output pending");

	// Valid bits hold while the pipeline is stalled
	a_stall_holds_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9}))
		else $error("valid bits moved during stall");

	// An accepted transaction enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted transaction missing from first stage");

endmodule
`default_nettype wire

### src/ipsv_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsv_sine_rom: dual-read sine lookup
// Constant Q24 table of SINE_TABLE_ENTRIES samples over one turn, built at
// elaboration, with registered sine and cosine reads.
// ----------------------------------------------------------------------------
module ipsv_sine_rom #(
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic [$clog2(SINE_TABLE_ENTRIES)-1:0] sin_idx,
	input  wire logic [$clog2(SINE_TABLE_ENTRIES)-1:0] cos_idx,
	output logic signed [31:0]                         sin_s2,
	output logic signed [31:0]                         cos_s2
);
	import ipsv_pkg::*;

	typedef logic signed [31:0] rom_t [SINE_TABLE_ENTRIES];

	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] phase;
		for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
			phase  = (64'(k) << 32) / SINE_TABLE_ENTRIES;
			rom[k] = sine_sample(phase);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Read both ports, hold on stall
	always_ff @(posedge clk) begin
		if (en) begin
			sin_s2 <= SINE_ROM[sin_idx];
			cos_s2 <= SINE_ROM[cos_idx];
		end
	end

endmodule
`default_nettype wire

### src/ipsv_duty.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsv_duty: sector decode and phase A duty
// Stage 6 takes the three sign tests and forms the duty operands, stage 7
// evaluates the phase A duty for the decoded sector.
// ----------------------------------------------------------------------------
module ipsv_duty (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               valid_s5,
	input  wire logic signed [31:0] va_s5,
	input  wire logic signed [31:0] ka_s5,
	input  wire logic signed [31:0] kb_s5,
	output logic                    valid_s7,
	output logic signed [31:0]      ta_s7
);
	import ipsv_pkg::*;

	logic               valid_s6;
	sector_t            sector_s6;
	logic signed [31:0] va_s6;
	logic signed [31:0] vb_s6;
	logic signed [31:0] vc_s6;

	logic signed [31:0] vb_test;
	logic signed [31:0] vc_test;
	logic signed [31:0] sum_a;
	logic signed [31:0] half_a;
	logic signed [31:0] mid_a;
	logic signed [31:0] ta_next;

	// Sign tests on the sector projections
	assign vb_test = ka_s5 - kb_s5;
	assign vc_test = -ka_s5 - kb_s5;

	// Stage 6: sector and duty operands
	always_ff @(posedge clk) begin
		if (en) begin
			sector_s6 <= sector_t'({vc_test > 0, vb_test > 0, va_s5 > 0});
			va_s6     <= va_s5;
			vb_s6     <= ka_s5 + kb_s5;
			vc_s6     <= kb_s5 - ka_s5;
		end
	end

	// Evaluate the sector formula; unused sectors give one half
	always_comb begin
		sum_a   = '0;
		half_a  = '0;
		mid_a   = '0;
		ta_next = Q24_HALF;
		case (sector_s6)
			SECT_1: begin
				sum_a   = Q24_ONE - vc_s6 - vb_s6;
				half_a  = sum_a >>> 1;
				ta_next = half_a + vc_s6;
			end
			SECT_2: begin
				sum_a   = Q24_ONE - vb_s6 + va_s6;
				ta_next = sum_a >>> 1;
			end
			SECT_3: begin
				sum_a   = Q24_ONE + vc_s6 - va_s6;
				ta_next = sum_a >>> 1;
			end
			SECT_4: begin
				sum_a   = Q24_ONE + va_s6 - vc_s6;
				half_a  = sum_a >>> 1;
				mid_a   = half_a - va_s6;
				ta_next = mid_a + vc_s6;
			end
			SECT_5: begin
				sum_a   = Q24_ONE - va_s6 + vb_s6;
				half_a  = sum_a >>> 1;
				mid_a   = half_a + va_s6;
				ta_next = mid_a - vb_s6;
			end
			SECT_6: begin
				sum_a   = Q24_ONE + vb_s6 + vc_s6;
				half_a  = sum_a >>> 1;
				ta_next = half_a - vb_s6;
			end
			default: begin
				ta_next = Q24_HALF;
			end
		endcase
	end

	// Stage 7: duty register
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s7 <= ta_next;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

endmodule
`default_nettype wire

### src/ipsv_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsv_skid: output register with skid stage
// Registered output transaction plus one spare entry, so the upstream
// ready is a flop and never depends on the downstream ready.
// ----------------------------------------------------------------------------
module ipsv_skid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ipsv_pkg::result_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ipsv_pkg::result_t      out_data
);
	import ipsv_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			if (!out_valid_q || out_ready)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (out_ready) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	// Payload: load output directly, park in skid, or drain skid
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (!out_valid_q || out_ready)
				out_data_q <= in_data;
			else
				skid_data_q <= in_data;
		end else if (out_ready && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end
	end

endmodule
`default_nettype wire

### bench/tb_inverse_park_svpwm_phase_a_drive.sv
// ----------------------------------------------------------------------------
// tb_inverse_park_svpwm_phase_a_drive: self-checking bench for phase A drive
// Sends rotor angle / alpha-beta / gain transactions, predicts the top and
// bottom predriver commands with an independent Q24 model of the rotation,
// sector decode and duty mapping, and checks every result in order under
// random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_inverse_park_svpwm_phase_a_drive;
	import ipsv_pkg::*;

	localparam int          SINE_N      = 1024;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          DRAIN_WAIT  = 40;
	localparam logic [63:0] HALF_PI_Q30_TB = 64'd1686629713;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// [23:0] angle_pu, [55:24] alpha_volt, [87:56] beta_volt, [119:88] drive_gain
	logic [119:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [31:0] top_command, [63:32] bottom_command
	logic [63:0]  m_axis_tdata;

	logic [31:0]  sine_lut [SINE_N];
	result_t      expected_cmds [$];
	int           error_count;
	int           cycle_count;
	bit           send_gaps_on;
	bit           recv_stalls_on;

	inverse_park_svpwm_phase_a_drive #(
		.SINE_TABLE_ENTRIES(SINE_N)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Fill the sine table: Q30 Taylor series on the first-quadrant angle
	task automatic build_sine_lut();
		logic [63:0]        phase;
		logic [1:0]         quad;
		logic [63:0]        r;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		logic [31:0]        v;
		for (int k = 0; k < SINE_N; k++) begin
			phase = (64'(k) << 32) / 64'(SINE_N);
			quad  = phase[31:30];
			r     = phase & 64'h3FFF_FFFF;
			if (quad[0])
				r = 64'h4000_0000 - r;
			x   = (r * HALF_PI_Q30_TB) >> 30;
			x2  = (x * x) >> 30;
			mag = x;
			sum = $signed(x);
			for (int n = 1; n <= 10; n++) begin
				mag = ((mag * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum = sum - $signed(mag);
				else
					sum = sum + $signed(mag);
			end
			if (sum < 0)
				sum = '0;
			if (sum > 64'sh4000_0000)
				sum = 64'sh4000_0000;
			v = 32'(($unsigned(sum) + 64'd32) >> 6);
			sine_lut[k] = quad[1] ? -v : v;
		end
	endtask

	// Q24 product: full signed 64-bit product, keep bits 55..24
	function automatic logic [31:0] q24_mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] prod;
		prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
		return prod[55:24];
	endfunction

	function automatic logic [31:0] half_of(input logic [31:0] v);
		return $signed(v) >>> 1;
	endfunction

	function automatic logic [31:0] sine_of(input logic [23:0] ang);
		logic [63:0] idx;
		idx = (64'(ang) * 64'(SINE_N)) >> 24;
		return sine_lut[idx[$clog2(SINE_N)-1:0]];
	endfunction

	// Predict the predriver commands for one control sample
	function automatic result_t drive_commands(input logic [23:0] ang, input logic [31:0] al,
			input logic [31:0] be, input logic [31:0] gain);
		logic [31:0] sn, cs, a1, b1, ka, kb, va, vb, vc, ta, tb, tc;
		sector_t     sector;
		result_t     res;
		sn = sine_of(ang);
		cs = sine_of(ang + 24'h40_0000);
		a1 = q24_mul(al, cs) + q24_mul(be, sn);
		b1 = q24_mul(be, cs) - q24_mul(al, sn);
		ka = q24_mul(a1, SQRT3_HALF_Q24);
		kb = half_of(b1);
		va = b1;
		vb = ka - kb;
		vc = -ka - kb;
		sector = sector_t'({$signed(vc) > 0, $signed(vb) > 0, $signed(va) > 0});
		vb = ka + kb;
		vc = -ka + kb;
		case (sector)
			SECT_1: begin
				tb = half_of(Q24_ONE - vc - vb);
				ta = tb + vc;
			end
			SECT_2: begin
				ta = half_of(Q24_ONE - vb + va);
			end
			SECT_3: begin
				ta = half_of(Q24_ONE + vc - va);
			end
			SECT_4: begin
				tc = half_of(Q24_ONE + va - vc);
				tb = tc - va;
				ta = tb + vc;
			end
			SECT_5: begin
				tb = half_of(Q24_ONE - va + vb);
				tc = tb + va;
				ta = tc - vb;
			end
			SECT_6: begin
				tc = half_of(Q24_ONE + vb + vc);
				ta = tc - vb;
			end
			default: begin
				// no sector, or all three tests true after wrap
				ta = Q24_HALF;
			end
		endcase
		ta = Q24_ONE - (ta << 1);
		res.top_command    = Q24_ONE + half_of(q24_mul(gain, ta - Q24_ONE));
		res.bottom_command = -Q24_ONE + half_of(q24_mul(gain, ta + Q24_ONE));
		return res;
	endfunction

	// Send one transaction after a random gap; record its prediction on acceptance
	task automatic send_sample(input logic [23:0] ang, input logic [31:0] al,
			input logic [31:0] be, input logic [31:0] gain);
		int gap;
		gap = send_gaps_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {gain, be, al, ang};
		do @(posedge clk); while (!s_axis_tready);
		expected_cmds.push_back(drive_commands(ang, al, be, gain));
	endtask

	// Corners of every field, zero vector and the quadrant boundaries
	task automatic test_field_extremes();
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
		send_sample(24'h00_0000, 32'h0000_0000, 32'h0000_0000, Q24_ONE);
		send_sample(24'hFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(24'h40_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_sample(24'h80_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		send_sample(24'hC0_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_sample(24'h3F_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, -Q24_ONE);
		send_sample(24'h00_0001, Q24_ONE, -Q24_ONE, 32'h7FFF_FFFF);
		send_sample(24'hFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
	endtask

	// One vector at the center of each of the six sectors at angle zero, and two more at a quarter turn
	task automatic test_each_sector();
		send_sample(24'h00_0000, 32'sd7264747, 32'sd4194304, Q24_ONE);
		send_sample(24'h00_0000, 32'sd0, 32'sd8388608, Q24_ONE);
		send_sample(24'h00_0000, -32'sd7264747, 32'sd4194304, Q24_ONE);
		send_sample(24'h00_0000, -32'sd7264747, -32'sd4194304, Q24_ONE);
		send_sample(24'h00_0000, 32'sd0, -32'sd8388608, Q24_ONE);
		send_sample(24'h00_0000, 32'sd7264747, -32'sd4194304, Q24_ONE);
		send_sample(24'h40_0000, 32'sd4194304, -32'sd7264747, Q24_HALF);
		send_sample(24'h40_0000, -32'sd4194304, 32'sd7264747, -Q24_HALF);
	endtask

	// All three sign tests true through wrap of the sqrt(3)/2 term
	task automatic test_sector_wrap();
		send_sample(24'h00_0000, 32'h8000_0000, 32'sd1000000000, Q24_ONE);
		send_sample(24'h00_0000, 32'h8000_0000, 32'sd1500000000, 32'h7FFF_FFFF);
		send_sample(24'h00_0000, 32'h8000_0000, 32'sd700000000, 32'h8000_0000);
	endtask

	// Random samples; extreme_pct of them use the full field range
	task automatic test_random_samples(input int count, input int extreme_pct, input bit idling);
		logic [23:0] ang;
		logic [31:0] al, be, gain;
		for (int i = 0; i < count; i++) begin
			// redraw idling per stretch so that bursts with no gaps occur too
			if (i % 40 == 0) begin
				send_gaps_on   = idling && ($urandom_range(0, 3) != 0);
				recv_stalls_on = idling && ($urandom_range(0, 3) != 0);
			end
			ang = 24'($urandom_range(0, 24'hFF_FFFF));
			if ($urandom_range(1, 100) <= extreme_pct) begin
				al   = $urandom;
				be   = $urandom;
				gain = $urandom;
			end else begin
				al   = $signed($urandom) >>> $urandom_range(4, 12);
				be   = $signed($urandom) >>> $urandom_range(4, 12);
				gain = $signed($urandom) >>> $urandom_range(5, 12);
			end
			send_sample(ang, al, be, gain);
		end
	endtask

	// Sink side: per result, stall a random number of cycles, then accept
	initial begin : sink_ready
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_stalls_on ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected result, actual top %h bottom %h", $time,
					got.top_command, got.bottom_command);
				error_count++;
			end else begin
				want = expected_cmds.pop_front();
				if (got.top_command !== want.top_command) begin
					$display("%0t: top_command mismatch, expected %h actual %h", $time,
						want.top_command, got.top_command);
					error_count++;
				end
				if (got.bottom_command !== want.bottom_command) begin
					$display("%0t: bottom_command mismatch, expected %h actual %h", $time,
						want.bottom_command, got.bottom_command);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		error_count    = 0;
		cycle_count    = 0;
		send_gaps_on   = 1'b0;
		recv_stalls_on = 1'b0;
		build_sine_lut();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_each_sector();
		test_sector_wrap();
		test_random_samples(900, 10, 1'b1);
		test_random_samples(500, 100, 1'b1);
		test_random_samples(200, 30, 1'b0);

		// drop valid, drain the pipeline, then allow stray results to show
		@(negedge clk);
		s_axis_tvalid  = 1'b0;
		recv_stalls_on = 1'b1;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0 && expected_cmds.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
src/ipsv_pkg.sv
src/ipsv_sine_rom.sv
src/ipsv_duty.sv
src/ipsv_skid.sv
src/inverse_park_svpwm_phase_a_drive.sv
bench/tb_inverse_park_svpwm_phase_a_drive.sv
